/* rtl/etcsf_pkg.sv */
// ----------------------------------------------------------------------------
// etcsf_pkg
// Shared widths, constants and types of the encoder turn counter / speed filter.
// ----------------------------------------------------------------------------
package etcsf_pkg;

   // field widths
   localparam int ANGLE_W    = 15;
   localparam int TURN_W     = 32;
   localparam int POS_W      = TURN_W + ANGLE_W;
   localparam int SPEED_W    = 15;
   localparam int DIFF_W     = 14;             // last good difference, +-DIFF_LIMIT
   localparam int RAW_DIFF_W = ANGLE_W + 1;
   localparam int PROD_W     = 28;             // DIFF_LIMIT * SCALE_NUM, signed

   // speed scaling and spike rejection
   localparam int SCALE_NUM  = 18311;
   localparam int SCALE_DEN  = 10000;
   localparam int DIFF_LIMIT = 5000;

   // divide by SCALE_DEN as a multiply by a rounded-up reciprocal;
   // exact for magnitudes below 2^(RECIP_SHIFT - 14)
   localparam int     RECIP_SHIFT = 41;
   localparam int     RECIP_W     = 28;
   localparam longint SCALE_RECIP = ((longint'(1) << RECIP_SHIFT) + longint'(SCALE_DEN) - 1)
                                    / longint'(SCALE_DEN);

   // angle sectors; a turn spans 2^ANGLE_W - 1 counts
   localparam int SECTOR_SHIFT = 12;
   localparam int SECTOR_W     = ANGLE_W - SECTOR_SHIFT;
   localparam logic [SECTOR_W-1:0] SECTOR_LOW    = SECTOR_W'(0);
   localparam logic [SECTOR_W-1:0] SECTOR_DISARM = SECTOR_W'(3);
   localparam logic [SECTOR_W-1:0] SECTOR_HIGH   = SECTOR_W'(7);

   // parameter defaults
   localparam int SHORT_DEPTH_DEF  = 16;
   localparam int MID_DEPTH_DEF    = 32;
   localparam int LONG_DEPTH_DEF   = 64;
   localparam int SPEED_DIVIDE_DEF = 10;

   localparam int NUM_WIN = 3;

   typedef enum logic [1:0] {
      WIN_SHORT,
      WIN_MID,
      WIN_LONG
   } win_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_SCALE,
      ST_QUOT,
      ST_RD,
      ST_WR,
      ST_AVG,
      ST_AVG_WAIT,
      ST_DONE
   } fsm_state_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* rtl/etcsf_ram.sv */
// ----------------------------------------------------------------------------
// etcsf_ram
// Generic single-port-per-direction RAM with registered read.
// ----------------------------------------------------------------------------
module etcsf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/etcsf_div.sv */
// ----------------------------------------------------------------------------
// etcsf_div
// Radix-2 restoring divider, one quotient bit per cycle, signed dividend,
// positive divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module etcsf_div #(
   parameter int DVD_W = 28,
   parameter int DEN_W = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [DVD_W-1:0] dividend,
   input  logic [DEN_W-1:0]        divisor,
   output logic                    busy,
   output logic                    done,
   output logic signed [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_sub;
   logic             trial_ge;

   assign trial     = {rem_ff, quo_ff[DVD_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign trial_ge  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DVD_W-1];
         cnt_in  = CNT_W'(DVD_W);
         quo_in  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], trial_ge};
         rem_in = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still iterating");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("divider iterating with no bits left");

endmodule

/* rtl/etcsf_turn.sv */
// ----------------------------------------------------------------------------
// etcsf_turn
// Turn counter on angle sector crossings and multi-turn position.
// ----------------------------------------------------------------------------
module etcsf_turn (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tick,
   input  logic [etcsf_pkg::ANGLE_W-1:0]        tick_angle,
   input  logic [etcsf_pkg::ANGLE_W-1:0]        cur_angle,
   output logic signed [etcsf_pkg::POS_W-1:0]   position
);

   import etcsf_pkg::*;

   logic [TURN_W-1:0]   count_ff, count_in;
   logic                up_armed_ff, up_armed_in;
   logic                down_armed_ff, down_armed_in;
   logic [SECTOR_W-1:0] sector;
   logic [POS_W-1:0]    count_shl;
   logic [POS_W-1:0]    count_ext;

   assign sector = tick_angle[ANGLE_W-1:SECTOR_SHIFT];

   always_comb begin
      count_in      = count_ff;
      up_armed_in   = up_armed_ff;
      down_armed_in = down_armed_ff;
      if (tick) begin
         unique case (sector)
            SECTOR_LOW: begin
               if (up_armed_ff) begin
                  count_in    = count_ff + TURN_W'(1);
                  up_armed_in = 1'b0;
               end
               down_armed_in = 1'b1;
            end
            SECTOR_HIGH: begin
               if (down_armed_ff) begin
                  count_in      = count_ff - TURN_W'(1);
                  down_armed_in = 1'b0;
               end
               up_armed_in = 1'b1;
            end
            SECTOR_DISARM: begin
               up_armed_in   = 1'b0;
               down_armed_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         up_armed_ff   <= 1'b0;
         down_armed_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         up_armed_ff   <= up_armed_in;
         down_armed_ff <= down_armed_in;
      end
   end

   // count * (2^15 - 1) as a shift and a subtract
   assign count_shl = {count_ff, ANGLE_W'(0)};
   assign count_ext = {{ANGLE_W{count_ff[TURN_W-1]}}, count_ff};
   assign position  = $signed(count_shl - count_ext + {TURN_W'(0), cur_angle});

endmodule

/* rtl/encoder_turn_count_speed_filter_core.sv */
// ----------------------------------------------------------------------------
// encoder_turn_count_speed_filter_core
// Multi-turn encoder position with decimated speed and three moving averages.
// ----------------------------------------------------------------------------
// Usage:
//   One rotor angle enters per req_ transfer; exactly one result leaves per
//   item on the rsp_ channel, in order. Turn counting and position are updated
//   on every item. Every SPEED_DIVIDE items the angle difference is scaled and
//   pushed into three windows held in one shared RAM; rsp_speed_updated marks
//   those results, and speed and averages hold between them.
//   Flow: an item without speed update goes from transfer straight to the
//   result register. An update item first forms the difference and the
//   18311/10000 scaling by a reciprocal multiply, then per window does a
//   RAM read-modify-write and one pass through the single bit-serial
//   divider.
//   One item is processed at a time; the next is taken as soon as the result
//   sits in the output register, even while the receiver stalls it.
//   Reset: synchronous; clears turn count, armed flags, held speed and
//   averages, window pointers and sums. Window RAM needs no clearing, since
//   a read-back entry is only used once its window has filled.
// ----------------------------------------------------------------------------
module encoder_turn_count_speed_filter_core #(
   parameter int SHORT_DEPTH  = etcsf_pkg::SHORT_DEPTH_DEF,
   parameter int MID_DEPTH    = etcsf_pkg::MID_DEPTH_DEF,
   parameter int LONG_DEPTH   = etcsf_pkg::LONG_DEPTH_DEF,
   parameter int SPEED_DIVIDE = etcsf_pkg::SPEED_DIVIDE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [etcsf_pkg::ANGLE_W-1:0]         req_rotor_angle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [etcsf_pkg::POS_W-1:0]    rsp_multi_turn_position,
   output logic signed [etcsf_pkg::SPEED_W-1:0]  rsp_speed,
   output logic signed [etcsf_pkg::SPEED_W-1:0]  rsp_speed_avg_short,
   output logic signed [etcsf_pkg::SPEED_W-1:0]  rsp_speed_avg_mid,
   output logic signed [etcsf_pkg::SPEED_W-1:0]  rsp_speed_avg_long,
   output logic                                  rsp_speed_updated
);

   import etcsf_pkg::*;

   localparam int MAX_DEPTH    = max_int(max_int(SHORT_DEPTH, MID_DEPTH), LONG_DEPTH);
   localparam int TOTAL        = SHORT_DEPTH + MID_DEPTH + LONG_DEPTH;
   localparam int ADDR_W       = $clog2(TOTAL);
   localparam int PTR_W        = $clog2(MAX_DEPTH);
   localparam int CNT_W        = $clog2(MAX_DEPTH + 1);
   localparam int SUM_W        = SPEED_W + $clog2(MAX_DEPTH);
   localparam int DVD_W        = SUM_W;
   localparam int DEN_W        = CNT_W;
   localparam int TICK_W       = $clog2(SPEED_DIVIDE + 1);
   localparam int RECIP_PROD_W = PROD_W + RECIP_W;

   localparam logic [TICK_W-1:0]            TICK_LAST = TICK_W'(SPEED_DIVIDE - 1);
   localparam logic signed [RAW_DIFF_W-1:0] LIMIT_POS = RAW_DIFF_W'(DIFF_LIMIT);
   localparam logic signed [RAW_DIFF_W-1:0] LIMIT_NEG = RAW_DIFF_W'(-DIFF_LIMIT);
   localparam logic signed [PROD_W-1:0]     SCALE_K   = PROD_W'(SCALE_NUM);
   localparam logic [RECIP_W-1:0]           RECIP_K   = RECIP_W'(SCALE_RECIP);

   // control
   fsm_state_type state_ff, state_in;
   logic          accept;
   logic          div_start;
   logic          ram_rd_en;
   logic          ram_wr_en;
   logic          rsp_load;

   // datapath registers
   logic [ANGLE_W-1:0]        angle_ff, angle_in;
   logic [ANGLE_W-1:0]        prev_ff, prev_in;
   logic signed [DIFF_W-1:0]  good_ff, good_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [RECIP_PROD_W-1:0]   recip_ff, recip_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic                      upd_ff, upd_in;
   logic [TICK_W-1:0]         tick_ff, tick_in;
   win_type                   win_ff, win_in;
   logic [PTR_W-1:0]          ptr_ff [NUM_WIN];
   logic [PTR_W-1:0]          ptr_in [NUM_WIN];
   logic [NUM_WIN-1:0]        full_ff, full_in;
   logic signed [SUM_W-1:0]   sum_ff [NUM_WIN];
   logic signed [SUM_W-1:0]   sum_in [NUM_WIN];
   logic signed [SPEED_W-1:0] avg_ff [NUM_WIN];
   logic signed [SPEED_W-1:0] avg_in [NUM_WIN];
   logic [DEN_W-1:0]          den_ff, den_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic signed [SPEED_W-1:0] rsp_avg_ff [NUM_WIN];
   logic signed [SPEED_W-1:0] rsp_avg_in [NUM_WIN];
   logic                      rsp_upd_ff, rsp_upd_in;

   // combinational helpers
   logic signed [RAW_DIFF_W-1:0] raw_diff;
   logic signed [DIFF_W-1:0]     diff_sel;
   logic [PROD_W-1:0]            prod_mag;
   logic signed [SPEED_W-1:0]    quot_mag;
   logic [CNT_W-1:0]             depth_sel;
   logic [ADDR_W-1:0]            base_sel;
   logic [ADDR_W-1:0]            ram_addr;
   logic [CNT_W-1:0]             ptr_inc;
   logic                         ptr_wrap;
   logic signed [SPEED_W-1:0]    oldest;
   logic [SPEED_W-1:0]           ram_rd_data;
   logic signed [DVD_W-1:0]      div_dvd;
   logic [DEN_W-1:0]             div_den;
   logic                         div_busy;
   logic                         div_done;
   logic signed [DVD_W-1:0]      div_quo;
   logic signed [POS_W-1:0]      position;

   etcsf_turn u_turn (
      .clock      (clock),
      .reset      (reset),
      .tick       (accept),
      .tick_angle (req_rotor_angle),
      .cur_angle  (angle_ff),
      .position   (position)
   );

   etcsf_div #(
      .DVD_W (DVD_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_den),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   etcsf_ram #(
      .WIDTH (SPEED_W),
      .DEPTH (TOTAL)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (speed_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // window geometry inside the shared RAM
   always_comb begin
      unique case (win_ff)
         WIN_SHORT: begin
            depth_sel = CNT_W'(SHORT_DEPTH);
            base_sel  = '0;
         end
         WIN_MID: begin
            depth_sel = CNT_W'(MID_DEPTH);
            base_sel  = ADDR_W'(SHORT_DEPTH);
         end
         default: begin
            depth_sel = CNT_W'(LONG_DEPTH);
            base_sel  = ADDR_W'(SHORT_DEPTH + MID_DEPTH);
         end
      endcase
   end

   assign ram_addr = base_sel + ADDR_W'(ptr_ff[win_ff]);
   assign ptr_inc  = CNT_W'(ptr_ff[win_ff]) + CNT_W'(1);
   assign ptr_wrap = (ptr_inc >= depth_sel);
   assign oldest   = $signed(ram_rd_data);

   assign raw_diff = $signed({1'b0, angle_ff}) - $signed({1'b0, prev_ff});
   assign diff_sel = ((raw_diff > LIMIT_POS) || (raw_diff < LIMIT_NEG))
                     ? good_ff : raw_diff[DIFF_W-1:0];

   // magnitude times reciprocal, quotient in the top bits
   assign prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign quot_mag = $signed(recip_ff[RECIP_SHIFT +: SPEED_W]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (tick_ff == TICK_LAST) ? ST_DIFF : ST_DONE;
            end
         end
         ST_DIFF:       state_in = ST_MUL;
         ST_MUL:        state_in = ST_SCALE;
         ST_SCALE:      state_in = ST_QUOT;
         ST_QUOT:       state_in = ST_RD;
         ST_RD:         state_in = ST_WR;
         ST_WR:         state_in = ST_AVG;
         ST_AVG:        state_in = ST_AVG_WAIT;
         ST_AVG_WAIT: begin
            if (div_done) begin
               state_in = (win_ff == WIN_LONG) ? ST_DONE : ST_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      div_start = (state_ff == ST_AVG);
      ram_rd_en = (state_ff == ST_RD);
      ram_wr_en = (state_ff == ST_WR);
      rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      div_dvd   = DVD_W'(sum_ff[win_ff]);
      div_den   = den_ff;
   end

   assign accept = req_valid && req_ready;

   // datapath
   always_comb begin
      angle_in = angle_ff;
      prev_in  = prev_ff;
      good_in  = good_ff;
      diff_in  = diff_ff;
      prod_in  = prod_ff;
      recip_in = recip_ff;
      speed_in = speed_ff;
      upd_in   = upd_ff;
      tick_in  = tick_ff;
      win_in   = win_ff;
      full_in  = full_ff;
      den_in   = den_ff;
      for (int i = 0; i < NUM_WIN; i++) begin
         ptr_in[i] = ptr_ff[i];
         sum_in[i] = sum_ff[i];
         avg_in[i] = avg_ff[i];
      end

      if (accept) begin
         angle_in = req_rotor_angle;
         upd_in   = (tick_ff == TICK_LAST);
         tick_in  = (tick_ff == TICK_LAST) ? '0 : tick_ff + TICK_W'(1);
      end

      if (state_ff == ST_DIFF) begin
         diff_in = diff_sel;
         good_in = diff_sel;
         prev_in = angle_ff;
      end

      if (state_ff == ST_MUL) begin
         prod_in = PROD_W'(diff_ff) * SCALE_K;
      end

      if (state_ff == ST_SCALE) begin
         recip_in = prod_mag * RECIP_K;
      end

      if (state_ff == ST_QUOT) begin
         speed_in = prod_ff[PROD_W-1] ? -quot_mag : quot_mag;
         win_in   = WIN_SHORT;
      end

      // read data of the oldest entry is valid here; same entry gets the new sample
      if (state_ff == ST_WR) begin
         if (full_ff[win_ff]) begin
            sum_in[win_ff] = sum_ff[win_ff] + SUM_W'(speed_ff) - SUM_W'(oldest);
            den_in         = DEN_W'(depth_sel);
         end else begin
            sum_in[win_ff] = sum_ff[win_ff] + SUM_W'(speed_ff);
            den_in         = DEN_W'(ptr_inc);
         end
         ptr_in[win_ff]  = ptr_wrap ? '0 : ptr_inc[PTR_W-1:0];
         full_in[win_ff] = full_ff[win_ff] | ptr_wrap;
      end

      if ((state_ff == ST_AVG_WAIT) && div_done) begin
         avg_in[win_ff] = div_quo[SPEED_W-1:0];
         unique case (win_ff)
            WIN_SHORT: win_in = WIN_MID;
            default:   win_in = WIN_LONG;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_upd_in   = rsp_upd_ff;
      for (int i = 0; i < NUM_WIN; i++) begin
         rsp_avg_in[i] = rsp_avg_ff[i];
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = position;
         rsp_speed_in = speed_ff;
         rsp_upd_in   = upd_ff;
         for (int i = 0; i < NUM_WIN; i++) begin
            rsp_avg_in[i] = avg_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         good_ff      <= '0;
         speed_ff     <= '0;
         tick_ff      <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_WIN; i++) begin
            ptr_ff[i] <= '0;
            sum_ff[i] <= '0;
            avg_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         good_ff      <= good_in;
         speed_ff     <= speed_in;
         tick_ff      <= tick_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_WIN; i++) begin
            ptr_ff[i] <= ptr_in[i];
            sum_ff[i] <= sum_in[i];
            avg_ff[i] <= avg_in[i];
         end
      end
      angle_ff     <= angle_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      recip_ff     <= recip_in;
      upd_ff       <= upd_in;
      win_ff       <= win_in;
      den_ff       <= den_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_upd_ff   <= rsp_upd_in;
      for (int i = 0; i < NUM_WIN; i++) begin
         rsp_avg_ff[i] <= rsp_avg_in[i];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_multi_turn_position = rsp_pos_ff;
   assign rsp_speed               = rsp_speed_ff;
   assign rsp_speed_avg_short     = rsp_avg_ff[WIN_SHORT];
   assign rsp_speed_avg_mid       = rsp_avg_ff[WIN_MID];
   assign rsp_speed_avg_long      = rsp_avg_ff[WIN_LONG];
   assign rsp_speed_updated       = rsp_upd_ff;

   a_idle_div_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_busy)
      else $error("divider still busy while taking a new item");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_AVG_WAIT))
      else $error("divider result arrived outside a wait state");

   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((full_ff & $past(full_ff)) == $past(full_ff)))
      else $error("window full flag dropped");

endmodule

/* tb/etcsf_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etcsf_result_checker
// Watches both channels of the encoder turn counter / speed filter, predicts
// every result from the accepted angles and compares it field by field.
// ----------------------------------------------------------------------------
module etcsf_result_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [etcsf_pkg::ANGLE_W-1:0]         req_rotor_angle,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [etcsf_pkg::POS_W-1:0]    rsp_multi_turn_position,
   input  logic signed [etcsf_pkg::SPEED_W-1:0]  rsp_speed,
   input  logic signed [etcsf_pkg::SPEED_W-1:0]  rsp_speed_avg_short,
   input  logic signed [etcsf_pkg::SPEED_W-1:0]  rsp_speed_avg_mid,
   input  logic signed [etcsf_pkg::SPEED_W-1:0]  rsp_speed_avg_long,
   input  logic                                  rsp_speed_updated,
   output int                                    outstanding,
   output int                                    failures
);

   import etcsf_pkg::*;

   localparam longint TURN_SPAN   = (longint'(1) << ANGLE_W) - 1;
   localparam int     STORE_DEPTH = 256;

   typedef struct {
      logic signed [POS_W-1:0]   position;
      logic signed [SPEED_W-1:0] speed;
      logic signed [SPEED_W-1:0] avg_short;
      logic signed [SPEED_W-1:0] avg_mid;
      logic signed [SPEED_W-1:0] avg_long;
      logic                      updated;
   } encoder_result_type;

   encoder_result_type due_results[$];
   int fail_total = 0;
   int result_index = 0;

   // predicted block state
   logic [TURN_W-1:0]         turn_count;
   logic                      up_armed;
   logic                      down_armed;
   int                        tick_count;
   logic [ANGLE_W-1:0]        prev_angle;
   int                        good_diff;
   logic signed [SPEED_W-1:0] speed_now;
   logic signed [SPEED_W-1:0] win_store [NUM_WIN][STORE_DEPTH];
   int                        win_depth [NUM_WIN];
   int                        win_ptr [NUM_WIN];
   logic                      win_full [NUM_WIN];
   longint                    win_sum [NUM_WIN];
   logic signed [SPEED_W-1:0] win_avg [NUM_WIN];

   assign failures = fail_total;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_total++;
   endtask

   function automatic void clear_prediction();
      turn_count = '0;
      up_armed   = 1'b0;
      down_armed = 1'b0;
      tick_count = 0;
      prev_angle = '0;
      good_diff  = 0;
      speed_now  = '0;
      win_depth[WIN_SHORT] = SHORT_DEPTH_DEF;
      win_depth[WIN_MID]   = MID_DEPTH_DEF;
      win_depth[WIN_LONG]  = LONG_DEPTH_DEF;
      for (int w = 0; w < NUM_WIN; w++) begin
         win_ptr[w]  = 0;
         win_full[w] = 1'b0;
         win_sum[w]  = 0;
         win_avg[w]  = '0;
      end
   endfunction

   function automatic void push_speed_sample(input int w, input logic signed [SPEED_W-1:0] s);
      int slot;
      logic signed [SPEED_W-1:0] oldest;
      slot = win_ptr[w];
      oldest = win_store[w][slot];
      win_sum[w] += s;
      win_store[w][slot] = s;
      win_ptr[w] = slot + 1;
      if (!win_full[w]) begin
         // still filling: divide by the samples so far
         win_avg[w] = SPEED_W'(win_sum[w] / longint'(win_ptr[w]));
         if (win_ptr[w] >= win_depth[w]) begin
            win_full[w] = 1'b1;
            win_ptr[w]  = 0;
         end
      end else begin
         win_sum[w] -= oldest;
         win_avg[w] = SPEED_W'(win_sum[w] / longint'(win_depth[w]));
         if (win_ptr[w] >= win_depth[w])
            win_ptr[w] = 0;
      end
   endfunction

   function automatic encoder_result_type track_angle(input logic [ANGLE_W-1:0] angle);
      logic [SECTOR_W-1:0]      sector;
      logic signed [TURN_W-1:0] turns;
      int                       diff;
      encoder_result_type       r;
      sector = angle[ANGLE_W-1 -: SECTOR_W];
      r.updated = 1'b0;
      if (sector == SECTOR_LOW) begin
         if (up_armed) begin
            turn_count = turn_count + 1'b1;
            up_armed   = 1'b0;
         end
         down_armed = 1'b1;
      end else if (sector == SECTOR_HIGH) begin
         if (down_armed) begin
            turn_count = turn_count - 1'b1;
            down_armed = 1'b0;
         end
         up_armed = 1'b1;
      end else if (sector == SECTOR_DISARM) begin
         up_armed   = 1'b0;
         down_armed = 1'b0;
      end
      turns = turn_count;
      r.position = POS_W'(longint'(turns) * TURN_SPAN + longint'(angle));

      tick_count++;
      if (tick_count >= SPEED_DIVIDE_DEF) begin
         tick_count = 0;
         diff = int'(angle) - int'(prev_angle);
         prev_angle = angle;
         // spike rejection: reuse the last accepted difference
         if (diff > DIFF_LIMIT || diff < -DIFF_LIMIT)
            diff = good_diff;
         good_diff = diff;
         speed_now = SPEED_W'((diff * SCALE_NUM) / SCALE_DEN);
         for (int w = 0; w < NUM_WIN; w++)
            push_speed_sample(w, speed_now);
         r.updated = 1'b1;
      end
      r.speed     = speed_now;
      r.avg_short = win_avg[WIN_SHORT];
      r.avg_mid   = win_avg[WIN_MID];
      r.avg_long  = win_avg[WIN_LONG];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      encoder_result_type want;
      if (reset) begin
         clear_prediction();
         due_results.delete();
         outstanding <= 0;
      end else begin
         // compare before queuing so a stray result is never matched to a new item
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_index));
            end else begin
               want = due_results.pop_front();
               if (rsp_multi_turn_position !== want.position)
                  report_mismatch($sformatf("result %0d position got %0d want %0d",
                     result_index, rsp_multi_turn_position, want.position));
               if (rsp_speed !== want.speed)
                  report_mismatch($sformatf("result %0d speed got %0d want %0d",
                     result_index, rsp_speed, want.speed));
               if (rsp_speed_avg_short !== want.avg_short)
                  report_mismatch($sformatf("result %0d avg_short got %0d want %0d",
                     result_index, rsp_speed_avg_short, want.avg_short));
               if (rsp_speed_avg_mid !== want.avg_mid)
                  report_mismatch($sformatf("result %0d avg_mid got %0d want %0d",
                     result_index, rsp_speed_avg_mid, want.avg_mid));
               if (rsp_speed_avg_long !== want.avg_long)
                  report_mismatch($sformatf("result %0d avg_long got %0d want %0d",
                     result_index, rsp_speed_avg_long, want.avg_long));
               if (rsp_speed_updated !== want.updated)
                  report_mismatch($sformatf("result %0d speed_updated got %0b want %0b",
                     result_index, rsp_speed_updated, want.updated));
            end
            result_index++;
         end
         if (req_valid && req_ready)
            due_results.push_back(track_angle(req_rotor_angle));
         outstanding <= due_results.size();
      end
   end

endmodule

/* tb/tb_encoder_turn_count_speed_filter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_turn_count_speed_filter_core
// Drives rotor angles into the turn counter / speed filter: a directed
// sequence through the sectors and the spike limit, then smooth rotations with
// random speed and reversals mixed with noise, under several idle patterns.
// ----------------------------------------------------------------------------
module tb_encoder_turn_count_speed_filter_core;
   import etcsf_pkg::*;

   localparam int RANDOM_ITEMS = 1750;
   localparam int PHASE_ITEMS  = 350;
   localparam int DRAIN_CYCLES = 300;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ANGLE_W-1:0]        req_rotor_angle = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [POS_W-1:0]   rsp_multi_turn_position;
   logic signed [SPEED_W-1:0] rsp_speed;
   logic signed [SPEED_W-1:0] rsp_speed_avg_short;
   logic signed [SPEED_W-1:0] rsp_speed_avg_mid;
   logic signed [SPEED_W-1:0] rsp_speed_avg_long;
   logic                      rsp_speed_updated;
   int                        outstanding;
   int                        failures;

   int idle_pct  = 0;
   int stall_pct = 0;

   always #5 clock = ~clock;

   encoder_turn_count_speed_filter_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_rotor_angle         (req_rotor_angle),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_multi_turn_position (rsp_multi_turn_position),
      .rsp_speed               (rsp_speed),
      .rsp_speed_avg_short     (rsp_speed_avg_short),
      .rsp_speed_avg_mid       (rsp_speed_avg_mid),
      .rsp_speed_avg_long      (rsp_speed_avg_long),
      .rsp_speed_updated       (rsp_speed_updated)
   );

   etcsf_result_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_rotor_angle         (req_rotor_angle),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_multi_turn_position (rsp_multi_turn_position),
      .rsp_speed               (rsp_speed),
      .rsp_speed_avg_short     (rsp_speed_avg_short),
      .rsp_speed_avg_mid       (rsp_speed_avg_mid),
      .rsp_speed_avg_long      (rsp_speed_avg_long),
      .rsp_speed_updated       (rsp_speed_updated),
      .outstanding             (outstanding),
      .failures                (failures)
   );

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // valid is only lowered when a gap follows, so it never toggles within one step
   task automatic send_angle(input logic [ANGLE_W-1:0] angle);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct)
            @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rotor_angle <= angle;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // sector walk, armed flags, and the spike limit at both sides of +5000
   logic [ANGLE_W-1:0] directed_angles [20] = '{
      15'd0, 15'd32767, 15'd0, 15'd12288, 15'd28672,
      15'd4095, 15'd16384, 15'd30000, 15'd32767, 15'd5000,
      15'd8192, 15'd20480, 15'd24576, 15'd12287, 15'd1,
      15'd32767, 15'd2000, 15'd10000, 15'd3000, 15'd10001
   };

   initial begin : stimulus
      logic [ANGLE_W-1:0] angle;
      int sent;
      int phase;
      int mode;
      int run_len;
      int step;
      int jitter;
      int pick;
      bit exact;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_angles[i])
         send_angle(directed_angles[i]);
      drain_results();

      angle = directed_angles[19];
      sent  = 0;
      phase = -1;
      while (sent < RANDOM_ITEMS) begin
         if (sent / PHASE_ITEMS != phase) begin
            phase = sent / PHASE_ITEMS;
            // hold the sender until the block has emptied
            drain_results();
            unique case (phase % 5)
               0: begin idle_pct = 0;  stall_pct <= 0;  end
               1: begin idle_pct = 66; stall_pct <= 0;  end
               2: begin idle_pct = 0;  stall_pct <= 66; end
               3: begin idle_pct = 6;  stall_pct <= 6;  end
               default: begin idle_pct = 0; stall_pct <= 0; end
            endcase
         end
         mode = $urandom_range(99);
         if (mode < 75) begin
            // smooth rotation, occasionally reversing
            pick  = $urandom_range(9);
            exact = (pick == 0);
            if (pick == 0)
               step = 500;
            else if (pick == 1)
               step = $urandom_range(600, 501);
            else
               step = $urandom_range(499);
            if ($urandom_range(1))
               step = -step;
            run_len = $urandom_range(80, 10);
            for (int k = 0; k < run_len; k++) begin
               if ($urandom_range(99) < 5)
                  step = -step;
               jitter = exact ? 0 : $urandom_range(6) - 3;
               angle  = angle + ANGLE_W'(step + jitter);
               send_angle(angle);
               sent++;
            end
         end else if (mode < 90) begin
            run_len = $urandom_range(8, 1);
            for (int k = 0; k < run_len; k++) begin
               send_angle(ANGLE_W'($urandom_range(32767)));
               sent++;
            end
         end else begin
            // jump to a new place and keep rotating from there
            angle = ANGLE_W'($urandom_range(32767));
            send_angle(angle);
            sent++;
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("tb_encoder_turn_count_speed_filter_core OK");
      else
         $display("tb_encoder_turn_count_speed_filter_core NOT OK");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb_encoder_turn_count_speed_filter_core NOT OK");
      $finish;
   end

endmodule
